// File: rtl/gtnp_pkg.sv
// ----------------------------------------------------------------------------
// gtnp_pkg
// Shared types, codes and helpers of the glyph trim and nibble pack block.
// ----------------------------------------------------------------------------
package gtnp_pkg;

  localparam int unsigned DIM_W       = 9;
  localparam int unsigned OFF_FIELD_W = 20;
  localparam logic [7:0]  THRESH_RESET = 8'd48;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_FLUSH = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_META = 2'd0,
    KIND_DATA = 2'd1,
    KIND_NONE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_AREA,
    ST_READ,
    ST_NIB1,
    ST_NIB2,
    ST_FLUSH,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    RD_PEND,
    RD_SINGLE,
    RD_PAIR
  } rdsel_e;

  typedef struct packed {
    logic clear;
    logic step;
  } cur_ctrl_t;

  typedef struct packed {
    kind_e                  kind;
    logic [7:0]             data_byte;
    logic [7:0]             trim_width;
    logic [7:0]             trim_height;
    logic [10:0]            glyph_left;
    logic [10:0]            glyph_top;
    logic [OFF_FIELD_W-1:0] byte_offset;
    logic                   last_byte;
    logic                   overflow;
  } res_t;

  // (a*15+127)/255 through the reciprocal of 255
  function automatic logic [3:0] quant4(logic [7:0] a);
    logic [11:0] x;
    logic [12:0] s;
    x = 12'(a) * 12'd15 + 12'd127;
    s = 13'(x) + 13'(x >> 8) + 13'd1;
    return s[11:8];
  endfunction

endpackage

// File: rtl/gtnp_ram.sv
// ----------------------------------------------------------------------------
// gtnp_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module gtnp_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gtnp_cursor.sv
// ----------------------------------------------------------------------------
// gtnp_cursor
// Read cursor over the trimmed box: one step per nibble taken, row order.
// ----------------------------------------------------------------------------
module gtnp_cursor #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  gtnp_pkg::cur_ctrl_t                               ctrl_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]                      min_col_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0]                     min_row_i,
  input  logic [gtnp_pkg::DIM_W-1:0]                        box_w_i,
  input  logic [gtnp_pkg::DIM_W-1:0]                        box_h_i,
  output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0]   addr_o
);

  localparam int unsigned CB = $clog2(MAX_WIDTH);
  localparam int unsigned RB = $clog2(MAX_HEIGHT);
  localparam int unsigned DW = gtnp_pkg::DIM_W;

  logic [CB-1:0] col_q, col_d;
  logic [RB-1:0] row_q, row_d;
  logic [DW-1:0] col_inc, row_inc;

  always_comb begin
    col_inc = DW'(col_q) + DW'(1);
    row_inc = DW'(row_q) + DW'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (ctrl_i.clear) begin
      col_d = '0;
      row_d = '0;
    end else if (ctrl_i.step) begin
      if (col_inc >= box_w_i) begin
        col_d = '0;
        row_d = (row_inc >= box_h_i) ? '0 : row_inc[RB-1:0];
      end else begin
        col_d = col_inc[CB-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign addr_o = {RB'(min_row_i + row_q), CB'(min_col_i + col_q)};

endmodule

// File: rtl/glyph_trim_and_nibble_pack.sv
// ----------------------------------------------------------------------------
// glyph_trim_and_nibble_pack
// Trims a glyph alpha bitmap to its bounding box and packs it at 4 bpp.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel, tuser selecting load pixel, read
// byte or flush; tlast marks the final pixel of a glyph. Results leave on
// m_axis, tuser giving the kind: glyph metadata, data byte or no byte.
// A load without tlast gives no result; every other command gives one.
// The alpha threshold is written on the cfg channel while the block is idle.
// One command is worked on at a time and s_axis_tready is low meanwhile.
// States per command: load LOAD; last pixel LOAD, AREA, EMIT; flush FLUSH,
// EMIT; read byte READ, NIB1, NIB2 if two nibbles, EMIT; READ, EMIT if none.
// The nibble store is a single-port RAM with registered read, so each
// nibble's data is taken in the state after the one that gives its address.
// A result enters m_axis from EMIT when the output register is free; it waits
// there while the receiver stalls, and the block still takes and works on
// the next command, holding that result until the output register frees.
// Reset clears all control state but the read select and sets the threshold
// to 48; the nibble store is not cleared, no clearing pass runs.
// ----------------------------------------------------------------------------
module glyph_trim_and_nibble_pack #(
  parameter int unsigned MAX_WIDTH   = 128,
  parameter int unsigned MAX_HEIGHT  = 128,
  parameter int unsigned OFFSET_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // alpha_threshold
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_alpha, src_width, origin_left, origin_top, zero pad
  input  logic [39:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,   // mode
  input  logic        s_axis_tlast,   // last_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // data_byte, trim_width, trim_height, glyph_left, glyph_top,
  // byte_offset, overflow, zero pad
  output logic [71:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last_byte
);

  localparam int unsigned CB    = $clog2(MAX_WIDTH);
  localparam int unsigned RB    = $clog2(MAX_HEIGHT);
  localparam int unsigned LRW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AW    = CB + RB;
  localparam int unsigned DEPTH = MAX_HEIGHT * (2 ** CB);
  localparam int unsigned PT    = OFFSET_BITS + 1;
  localparam int unsigned OW    = (OFFSET_BITS > gtnp_pkg::OFF_FIELD_W) ?
                                  OFFSET_BITS : gtnp_pkg::OFF_FIELD_W;
  localparam int unsigned DW    = gtnp_pkg::DIM_W;
  localparam int unsigned RW    = 2 * DW;

  gtnp_pkg::state_e state_q, state_d;
  gtnp_pkg::rdsel_e rdsel_q, rdsel_d;
  gtnp_pkg::res_t   res_q, res_d, m_res_q;
  gtnp_pkg::cur_ctrl_t cur_ctrl;

  logic [7:0]     alpha_q, sw_q, thresh_q;
  logic [9:0]     left_q, top_q;
  logic           last_q;
  logic [7:0]     load_col_q, load_col_d;
  logic [LRW-1:0] load_row_q, load_row_d;
  logic [CB-1:0]  min_col_q, min_col_d, max_col_q, max_col_d;
  logic [RB-1:0]  min_row_q, min_row_d, max_row_q, max_row_d;
  logic           found_q, found_d, govf_q, govf_d, in_glyph_q, in_glyph_d;
  logic [RW-1:0]  rem_q, rem_d;
  logic [PT-1:0]  pix_q, pix_d, pix_inc;
  logic [3:0]     pend_nib_q, pend_nib_d, hi_nib_q, hi_nib_d;
  logic           pend_v_q, pend_v_d;
  logic           m_valid_q;

  logic           s_accept, out_free, out_load;
  logic           ram_we;
  logic [AW-1:0]  ram_addr, cur_addr;
  logic [3:0]     ram_rdata;
  logic [DW-1:0]  box_w, box_h, sw9, col_inc;
  logic           in_bounds, hit, found_cur;
  logic [CB-1:0]  col_c;
  logic [RB-1:0]  row_c;
  logic [OW-1:0]  off_ext;

  assign s_accept    = s_axis_tvalid && s_axis_tready;
  assign out_free    = !m_valid_q || m_axis_tready;
  assign out_load    = (state_q == gtnp_pkg::ST_EMIT) && out_free;
  assign cfg_ready_o = (state_q == gtnp_pkg::ST_IDLE);

  assign box_w     = DW'(max_col_q) - DW'(min_col_q) + DW'(1);
  assign box_h     = DW'(max_row_q) - DW'(min_row_q) + DW'(1);
  assign sw9       = (sw_q == 8'd0) ? DW'(256) : DW'(sw_q);
  assign col_inc   = DW'(load_col_q) + DW'(1);
  assign in_bounds = (DW'(load_col_q) < DW'(MAX_WIDTH)) && (load_row_q < LRW'(MAX_HEIGHT));
  assign hit       = in_bounds && (alpha_q > thresh_q);
  assign found_cur = in_glyph_q && found_q;
  assign col_c     = load_col_q[CB-1:0];
  assign row_c     = load_row_q[RB-1:0];
  assign pix_inc   = (pix_q == '1) ? pix_q : pix_q + PT'(1);
  assign off_ext   = OW'(pix_q >> 1);
  assign ram_addr  = (state_q == gtnp_pkg::ST_LOAD) ? {row_c, col_c} : cur_addr;

  gtnp_ram #(
    .WIDTH (4),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (gtnp_pkg::quant4(alpha_q)),
    .rdata_o (ram_rdata)
  );

  gtnp_cursor #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cursor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (cur_ctrl),
    .min_col_i (min_col_q),
    .min_row_i (min_row_q),
    .box_w_i   (box_w),
    .box_h_i   (box_h),
    .addr_o    (cur_addr)
  );

  always_comb begin
    state_d       = state_q;
    rdsel_d       = rdsel_q;
    res_d         = res_q;
    load_col_d    = load_col_q;
    load_row_d    = load_row_q;
    min_col_d     = min_col_q;
    max_col_d     = max_col_q;
    min_row_d     = min_row_q;
    max_row_d     = max_row_q;
    found_d       = found_q;
    govf_d        = govf_q;
    in_glyph_d    = in_glyph_q;
    rem_d         = rem_q;
    pix_d         = pix_q;
    pend_nib_d    = pend_nib_q;
    pend_v_d      = pend_v_q;
    hi_nib_d      = hi_nib_q;
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    cur_ctrl      = '0;

    unique case (state_q)
      gtnp_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_accept) begin
          unique case (gtnp_pkg::mode_e'(s_axis_tuser))
            gtnp_pkg::MODE_LOAD:  state_d = gtnp_pkg::ST_LOAD;
            gtnp_pkg::MODE_READ:  state_d = gtnp_pkg::ST_READ;
            gtnp_pkg::MODE_FLUSH: state_d = gtnp_pkg::ST_FLUSH;
            default:              state_d = gtnp_pkg::ST_IDLE;
          endcase
        end
      end

      gtnp_pkg::ST_LOAD: begin
        in_glyph_d = 1'b1;
        if (!in_glyph_q) begin
          govf_d  = 1'b0;
          found_d = 1'b0;
          rem_d   = '0;
        end
        if (in_bounds) begin
          ram_we = 1'b1;
          if (hit) begin
            found_d = 1'b1;
            if (!found_cur) begin
              min_col_d = col_c;
              max_col_d = col_c;
              min_row_d = row_c;
              max_row_d = row_c;
            end else begin
              if (col_c < min_col_q) min_col_d = col_c;
              if (col_c > max_col_q) max_col_d = col_c;
              if (row_c < min_row_q) min_row_d = row_c;
              if (row_c > max_row_q) max_row_d = row_c;
            end
          end
        end else begin
          govf_d = 1'b1;
        end
        if (col_inc >= sw9) begin
          load_col_d = '0;
          if (load_row_q < LRW'(MAX_HEIGHT)) load_row_d = load_row_q + LRW'(1);
        end else begin
          load_col_d = col_inc[7:0];
        end
        state_d = last_q ? gtnp_pkg::ST_AREA : gtnp_pkg::ST_IDLE;
      end

      gtnp_pkg::ST_AREA: begin
        res_d             = '0;
        res_d.kind        = gtnp_pkg::KIND_META;
        res_d.byte_offset = off_ext[gtnp_pkg::OFF_FIELD_W-1:0];
        res_d.overflow    = govf_q || (pix_q == '1);
        if (found_q) begin
          res_d.trim_width  = box_w[DW-1] ? 8'hFF : box_w[7:0];
          res_d.trim_height = box_h[DW-1] ? 8'hFF : box_h[7:0];
          res_d.glyph_left  = {left_q[9], left_q} + 11'(min_col_q);
          res_d.glyph_top   = {top_q[9], top_q} - 11'(min_row_q);
          rem_d             = box_w * box_h;
        end else begin
          rem_d = '0;
        end
        in_glyph_d     = 1'b0;
        load_col_d     = '0;
        load_row_d     = '0;
        cur_ctrl.clear = 1'b1;
        state_d        = gtnp_pkg::ST_EMIT;
      end

      gtnp_pkg::ST_READ: begin
        if (rem_q == '0) begin
          res_d      = '0;
          res_d.kind = gtnp_pkg::KIND_NONE;
          state_d    = gtnp_pkg::ST_EMIT;
        end else begin
          cur_ctrl.step = 1'b1;
          rem_d         = rem_q - RW'(1);
          pix_d         = pix_inc;
          if (pend_v_q) begin
            rdsel_d = gtnp_pkg::RD_PEND;
          end else if (rem_q == RW'(1)) begin
            rdsel_d = gtnp_pkg::RD_SINGLE;
          end else begin
            rdsel_d = gtnp_pkg::RD_PAIR;
          end
          state_d = gtnp_pkg::ST_NIB1;
        end
      end

      gtnp_pkg::ST_NIB1: begin
        unique case (rdsel_q)
          gtnp_pkg::RD_PEND: begin
            res_d           = '0;
            res_d.kind      = gtnp_pkg::KIND_DATA;
            res_d.data_byte = {pend_nib_q, ram_rdata};
            res_d.last_byte = (rem_q < RW'(2));
            pend_v_d        = 1'b0;
            state_d         = gtnp_pkg::ST_EMIT;
          end
          gtnp_pkg::RD_SINGLE: begin
            res_d      = '0;
            res_d.kind = gtnp_pkg::KIND_NONE;
            pend_nib_d = ram_rdata;
            pend_v_d   = 1'b1;
            state_d    = gtnp_pkg::ST_EMIT;
          end
          default: begin
            hi_nib_d      = ram_rdata;
            cur_ctrl.step = 1'b1;
            rem_d         = rem_q - RW'(1);
            pix_d         = pix_inc;
            state_d       = gtnp_pkg::ST_NIB2;
          end
        endcase
      end

      gtnp_pkg::ST_NIB2: begin
        res_d           = '0;
        res_d.kind      = gtnp_pkg::KIND_DATA;
        res_d.data_byte = {hi_nib_q, ram_rdata};
        res_d.last_byte = (rem_q < RW'(2));
        state_d         = gtnp_pkg::ST_EMIT;
      end

      gtnp_pkg::ST_FLUSH: begin
        res_d = '0;
        if (pend_v_q) begin
          res_d.kind      = gtnp_pkg::KIND_DATA;
          res_d.data_byte = {pend_nib_q, 4'h0};
          res_d.last_byte = 1'b1;
          pend_v_d        = 1'b0;
          pend_nib_d      = '0;
          if (pix_q[0] && (pix_q != '1)) pix_d = pix_q + PT'(1);
        end else begin
          res_d.kind = gtnp_pkg::KIND_NONE;
        end
        state_d = gtnp_pkg::ST_EMIT;
      end

      gtnp_pkg::ST_EMIT: begin
        if (out_free) state_d = gtnp_pkg::ST_IDLE;
      end

      default: state_d = gtnp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= gtnp_pkg::ST_IDLE;
      thresh_q   <= gtnp_pkg::THRESH_RESET;
      load_col_q <= '0;
      load_row_q <= '0;
      min_col_q  <= '0;
      max_col_q  <= '0;
      min_row_q  <= '0;
      max_row_q  <= '0;
      found_q    <= 1'b0;
      govf_q     <= 1'b0;
      in_glyph_q <= 1'b0;
      rem_q      <= '0;
      pix_q      <= '0;
      pend_nib_q <= '0;
      pend_v_q   <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_valid_i && cfg_ready_o) thresh_q <= cfg_data_i;
      load_col_q <= load_col_d;
      load_row_q <= load_row_d;
      min_col_q  <= min_col_d;
      max_col_q  <= max_col_d;
      min_row_q  <= min_row_d;
      max_row_q  <= max_row_d;
      found_q    <= found_d;
      govf_q     <= govf_d;
      in_glyph_q <= in_glyph_d;
      rem_q      <= rem_d;
      pix_q      <= pix_d;
      pend_nib_q <= pend_nib_d;
      pend_v_q   <= pend_v_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      alpha_q <= s_axis_tdata[7:0];
      sw_q    <= s_axis_tdata[15:8];
      left_q  <= s_axis_tdata[25:16];
      top_q   <= s_axis_tdata[35:26];
      last_q  <= s_axis_tlast;
    end
    rdsel_q  <= rdsel_d;
    hi_nib_q <= hi_nib_d;
    res_q    <= res_d;
    if (out_load) m_res_q <= res_q;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.kind;
  assign m_axis_tlast  = m_res_q.last_byte;
  assign m_axis_tdata  = {5'd0, m_res_q.overflow, m_res_q.byte_offset,
                          m_res_q.glyph_top, m_res_q.glyph_left,
                          m_res_q.trim_height, m_res_q.trim_width,
                          m_res_q.data_byte};

  a_write_only_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == gtnp_pkg::ST_LOAD))
    else $error("store written outside a pixel load");

  a_emit_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (state_q == gtnp_pkg::ST_IDLE) && m_axis_tvalid)
    else $error("result not placed in output register");

  a_pending_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pend_v_q) |-> ($past(state_q) == gtnp_pkg::ST_NIB1 ||
                         $past(state_q) == gtnp_pkg::ST_FLUSH))
    else $error("pending half byte dropped");

  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (pix_q >= $past(pix_q)))
    else $error("pixel total went backwards");

  a_second_nibble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gtnp_pkg::ST_NIB2) |-> (rdsel_q == gtnp_pkg::RD_PAIR))
    else $error("second nibble read without a pair");

endmodule
